// ===== rtl/pmd_pkg.sv =====
// Shared types and constants for the position PID motor drive.
`default_nettype none
package pmd_pkg;

    localparam int unsigned ACC_W = 82;

    localparam logic [7:0]  DUTY_MAX = 8'd255;

    localparam logic [31:0] GAIN_P_RESET = 32'd655;
    localparam logic [31:0] GAIN_D_RESET = 32'd6554;
    localparam logic [31:0] GAIN_I_RESET = 32'd0;
    localparam logic [15:0] CPR_RESET    = 16'd40800;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

    // degree scaling: x/360 = ((x >> 3) * ceil(2^28 / 45)) >> 28, exact for x < 2^25
    localparam logic [22:0] TGT_RCP      = 23'h5B_05B1;
    localparam logic [4:0]  TGT_RCP_LAST = 5'd1;

    // divider iteration count, minus one
    localparam logic [4:0] DIV_D_LAST = 5'd31;
    localparam logic [2:0] PROD_LAST  = 3'd7;

    typedef enum logic [1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_D = 2'd1,
        CFG_GAIN_I = 2'd2,
        CFG_CPR    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2
    } t_shift;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_TGT_MUL = 12'b0000_0000_0010,
        S_TGT_RCP = 12'b0000_0000_0100,
        S_ERR     = 12'b0000_0000_1000,
        S_DIFF    = 12'b0000_0001_0000,
        S_DIV_D   = 12'b0000_0010_0000,
        S_INT_MUL = 12'b0000_0100_0000,
        S_INT_ADD = 12'b0000_1000_0000,
        S_INT_ABS = 12'b0001_0000_0000,
        S_PROD    = 12'b0010_0000_0000,
        S_NEG     = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/pmd_in_if.sv =====
// Input channel: one control step request.
`default_nettype none
interface pmd_in_if;
    logic               valid;
    logic               ready;
    logic        [8:0]  target_degrees;
    logic signed [31:0] position_count;
    logic        [15:0] elapsed_ticks;

    modport source (output valid, output target_degrees, output position_count,
                    output elapsed_ticks, input ready);
    modport sink   (input valid, input target_degrees, input position_count,
                    input elapsed_ticks, output ready);
endinterface
`default_nettype wire

// ===== rtl/pmd_out_if.sv =====
// Output channel: one control step result.
`default_nettype none
interface pmd_out_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  duty;
    logic        [1:0]  direction;
    logic signed [31:0] control_value;

    modport source (output valid, output duty, output direction, output control_value,
                    input ready);
    modport sink   (input valid, input duty, input direction, input control_value,
                     output ready);
endinterface
`default_nettype wire

// ===== rtl/pid_motor_position_drive.sv =====
// Position PID motor drive: one shared multiplier and divider under a sequencer.
//
// Input channel i_in carries target angle, encoder count and elapsed ticks; output
// channel o_out carries duty, direction and the saturated control value u; both transfer
// on valid & ready. The user must write gains (Q16.16) and counts per revolution via
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; the block does not enforce it.
//
// One step at a time: i_in.ready is high only while the sequencer waits, so no new
// request is taken before the previous step has loaded the result register; the next
// request can transfer in the cycle after that load. The sequencer scales the target,
// clamps the error, runs the one-bit-per-cycle restoring divider (32 steps for the
// derivative, skipped when elapsed ticks is 0), updates the integral and sums seven
// 32x16 partial products through the shared multiplier; the degree scaling is a
// reciprocal multiply in three passes through the same multiplier.
//
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following result holds in the last sequencer
// state until the register frees. Synchronous reset restores the gains and counts
// per revolution, clears the stored previous error and integral and drops o_out.valid.
`default_nettype none
module pid_motor_position_drive (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pmd_in_if.sink      i_in,
    pmd_out_if.source   o_out,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);

    localparam int unsigned AW = pmd_pkg::ACC_W;

    pmd_pkg::t_state r_state, n_state;

    logic [31:0] r_kp, n_kp, r_kd, n_kd, r_ki, n_ki;
    logic [15:0] r_cpr, n_cpr;
    logic [31:0] r_prev, n_prev;
    logic [47:0] r_int, n_int;

    logic [8:0]  r_deg, n_deg;
    logic [31:0] r_pos, n_pos;
    logic [15:0] r_ticks, n_ticks;
    logic [31:0] r_err, n_err;
    logic [31:0] r_emag, n_emag;
    logic        r_eneg, n_eneg;
    logic [31:0] r_dmag, n_dmag;
    logic        r_dneg, n_dneg;
    logic [47:0] r_eprod, n_eprod;
    logic [47:0] r_imag, n_imag;
    logic        r_ineg, n_ineg;

    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_divisor, n_divisor;
    logic [4:0]  r_cnt, n_cnt;

    logic [2:0]  r_pcnt, n_pcnt;
    logic [47:0] r_pp, n_pp;
    logic        r_pp_neg, n_pp_neg;
    pmd_pkg::t_shift r_pp_sh, n_pp_sh;
    logic [AW-1:0] r_acc, n_acc;
    logic        r_sneg, n_sneg;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_duty, n_duty;
    logic [1:0]  r_dir, n_dir;
    logic [31:0] r_u, n_u;

    // shared multiplier
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;

    // partial product selection
    logic [31:0] g_sel, g_mag;
    logic [15:0] dig;
    logic        op_neg;
    pmd_pkg::t_shift dig_sh;

    // divider step
    logic [16:0] rem_sh, rem_nx;
    logic [31:0] quo_nx;
    logic        q_bit;

    logic [47:0] tgt_sum;
    logic [32:0] diff33, dd33, dd_abs;
    logic [48:0] int_add, int_sum;
    logic [AW-1:0] addend;
    logic [65:0] mag66;
    logic        sat_u;
    logic        out_load;

    assign i_in.ready        = (r_state == pmd_pkg::S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.duty        = r_duty;
    assign o_out.direction   = r_dir;
    assign o_out.control_value = r_u;

    // operand for the product phase
    always_comb begin
        g_sel  = '0;
        dig    = '0;
        op_neg = 1'b0;
        dig_sh = pmd_pkg::SH_0;
        unique case (r_pcnt)
            3'd0: begin
                g_sel = r_kp; dig = r_emag[15:0];  op_neg = r_eneg;
            end
            3'd1: begin
                g_sel = r_kp; dig = r_emag[31:16]; op_neg = r_eneg; dig_sh = pmd_pkg::SH_16;
            end
            3'd2: begin
                g_sel = r_kd; dig = r_dmag[15:0];  op_neg = r_dneg;
            end
            3'd3: begin
                g_sel = r_kd; dig = r_dmag[31:16]; op_neg = r_dneg; dig_sh = pmd_pkg::SH_16;
            end
            3'd4: begin
                g_sel = r_ki; dig = r_imag[15:0];  op_neg = r_ineg;
            end
            3'd5: begin
                g_sel = r_ki; dig = r_imag[31:16]; op_neg = r_ineg; dig_sh = pmd_pkg::SH_16;
            end
            3'd6: begin
                g_sel = r_ki; dig = r_imag[47:32]; op_neg = r_ineg; dig_sh = pmd_pkg::SH_32;
            end
            default: begin
                g_sel = '0;
            end
        endcase
        g_mag = g_sel[31] ? (~g_sel + 32'd1) : g_sel;
    end

    always_comb begin
        unique case (r_state)
            pmd_pkg::S_TGT_MUL: begin
                mul_a = {16'd0, r_cpr};
                mul_b = {7'd0, r_deg};
            end
            pmd_pkg::S_TGT_RCP: begin
                // low reciprocal half first, then the high half
                mul_a = r_quo;
                mul_b = (r_cnt == '0) ? {9'd0, pmd_pkg::TGT_RCP[22:16]}
                                      : pmd_pkg::TGT_RCP[15:0];
            end
            pmd_pkg::S_INT_MUL: begin
                mul_a = r_emag;
                mul_b = r_ticks;
            end
            default: begin
                mul_a = g_mag;
                mul_b = dig;
            end
        endcase
        mul_p = {16'd0, mul_a} * {32'd0, mul_b};
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem[15:0], r_quo[31]};
        q_bit  = (rem_sh >= {1'b0, r_divisor});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_divisor}) : rem_sh;
        quo_nx = {r_quo[30:0], q_bit};
    end

    always_comb begin
        unique case (r_pp_sh)
            pmd_pkg::SH_16: addend = {{(AW-64){1'b0}}, r_pp, 16'd0};
            pmd_pkg::SH_32: addend = {{(AW-80){1'b0}}, r_pp, 32'd0};
            default:        addend = {{(AW-48){1'b0}}, r_pp};
        endcase
    end

    always_comb begin
        tgt_sum = r_eprod + {mul_p[31:0], 16'd0};
        diff33  = {r_pos[31], r_pos} - {8'd0, r_quo[24:0]};
        dd33    = {r_err[31], r_err} - {r_prev[31], r_prev};
        dd_abs  = dd33[32] ? (~dd33 + 33'd1) : dd33;
        int_add = r_eneg ? (~{1'b0, r_eprod} + 49'd1) : {1'b0, r_eprod};
        int_sum = {r_int[47], r_int} + int_add;
        mag66   = r_acc[AW-1:16];
        sat_u   = |mag66[65:31];
        out_load = (r_state == pmd_pkg::S_OUT) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state = r_state;
        n_kp = r_kp; n_kd = r_kd; n_ki = r_ki; n_cpr = r_cpr;
        n_prev = r_prev; n_int = r_int;
        n_deg = r_deg; n_pos = r_pos; n_ticks = r_ticks;
        n_err = r_err; n_emag = r_emag; n_eneg = r_eneg;
        n_dmag = r_dmag; n_dneg = r_dneg; n_eprod = r_eprod;
        n_imag = r_imag; n_ineg = r_ineg;
        n_quo = r_quo; n_rem = r_rem; n_divisor = r_divisor; n_cnt = r_cnt;
        n_pcnt = r_pcnt; n_pp = r_pp; n_pp_neg = r_pp_neg; n_pp_sh = r_pp_sh;
        n_acc = r_acc; n_sneg = r_sneg;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_duty = r_duty; n_dir = r_dir; n_u = r_u;

        if (i_cfg_we) begin
            unique case (pmd_pkg::t_cfg_idx'(i_cfg_idx))
                pmd_pkg::CFG_GAIN_P: n_kp  = i_cfg_data;
                pmd_pkg::CFG_GAIN_D: n_kd  = i_cfg_data;
                pmd_pkg::CFG_GAIN_I: n_ki  = i_cfg_data;
                pmd_pkg::CFG_CPR:    n_cpr = i_cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (r_state)
            pmd_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_deg   = i_in.target_degrees;
                    n_pos   = i_in.position_count;
                    n_ticks = i_in.elapsed_ticks;
                    n_state = pmd_pkg::S_TGT_MUL;
                end
            end
            pmd_pkg::S_TGT_MUL: begin
                // product / 8, then the reciprocal of 45 finishes the scaling
                n_quo   = {10'd0, mul_p[24:3]};
                n_cnt   = pmd_pkg::TGT_RCP_LAST;
                n_state = pmd_pkg::S_TGT_RCP;
            end
            pmd_pkg::S_TGT_RCP: begin
                if (r_cnt == '0) begin
                    n_quo   = {15'd0, tgt_sum[44:28]};
                    n_state = pmd_pkg::S_ERR;
                end else begin
                    n_eprod = mul_p;
                    n_cnt   = r_cnt - 5'd1;
                end
            end
            pmd_pkg::S_ERR: begin
                if (diff33[32] != diff33[31])
                    n_err = diff33[32] ? pmd_pkg::S32_MIN : pmd_pkg::S32_MAX;
                else
                    n_err = diff33[31:0];
                n_state = pmd_pkg::S_DIFF;
            end
            pmd_pkg::S_DIFF: begin
                n_eneg = r_err[31];
                n_emag = r_err[31] ? (~r_err + 32'd1) : r_err;
                n_dneg = dd33[32];
                if (r_ticks == '0) begin
                    n_dmag  = '0;
                    n_state = pmd_pkg::S_INT_MUL;
                end else begin
                    n_quo     = dd_abs[31:0];
                    n_rem     = '0;
                    n_divisor = r_ticks;
                    n_cnt     = pmd_pkg::DIV_D_LAST;
                    n_state   = pmd_pkg::S_DIV_D;
                end
            end
            pmd_pkg::S_DIV_D: begin
                n_quo = quo_nx;
                n_rem = rem_nx;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_dmag  = quo_nx;
                    n_state = pmd_pkg::S_INT_MUL;
                end
            end
            pmd_pkg::S_INT_MUL: begin
                n_eprod = mul_p;
                n_state = pmd_pkg::S_INT_ADD;
            end
            pmd_pkg::S_INT_ADD: begin
                if (int_sum[48] != int_sum[47])
                    n_int = int_sum[48] ? pmd_pkg::S48_MIN : pmd_pkg::S48_MAX;
                else
                    n_int = int_sum[47:0];
                n_prev  = r_err;
                n_state = pmd_pkg::S_INT_ABS;
            end
            pmd_pkg::S_INT_ABS: begin
                n_ineg   = r_int[47];
                n_imag   = r_int[47] ? (~r_int + 48'd1) : r_int;
                n_acc    = '0;
                n_pp     = '0;
                n_pp_neg = 1'b0;
                n_pp_sh  = pmd_pkg::SH_0;
                n_pcnt   = '0;
                n_state  = pmd_pkg::S_PROD;
            end
            pmd_pkg::S_PROD: begin
                // accumulate last product while the next one is formed
                n_acc    = r_pp_neg ? (r_acc - addend) : (r_acc + addend);
                n_pp     = mul_p;
                n_pp_neg = g_sel[31] ^ op_neg;
                n_pp_sh  = dig_sh;
                n_pcnt   = r_pcnt + 3'd1;
                if (r_pcnt == pmd_pkg::PROD_LAST) n_state = pmd_pkg::S_NEG;
            end
            pmd_pkg::S_NEG: begin
                n_sneg  = r_acc[AW-1];
                n_acc   = r_acc[AW-1] ? (~r_acc + {{(AW-1){1'b0}}, 1'b1}) : r_acc;
                n_state = pmd_pkg::S_OUT;
            end
            pmd_pkg::S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    if (sat_u)
                        n_u = r_sneg ? pmd_pkg::S32_MIN : pmd_pkg::S32_MAX;
                    else
                        n_u = r_sneg ? (~mag66[31:0] + 32'd1) : mag66[31:0];
                    // a negative sum under one LSB truncates to zero: stop
                    if (mag66 == '0)
                        n_dir = pmd_pkg::DIR_STOP;
                    else
                        n_dir = r_sneg ? pmd_pkg::DIR_CCW : pmd_pkg::DIR_CW;
                    n_duty  = (|mag66[65:8]) ? pmd_pkg::DUTY_MAX : mag66[7:0];
                    n_state = pmd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pmd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmd_pkg::S_IDLE;
            r_kp        <= pmd_pkg::GAIN_P_RESET;
            r_kd        <= pmd_pkg::GAIN_D_RESET;
            r_ki        <= pmd_pkg::GAIN_I_RESET;
            r_cpr       <= pmd_pkg::CPR_RESET;
            r_prev      <= '0;
            r_int       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kp        <= n_kp;
            r_kd        <= n_kd;
            r_ki        <= n_ki;
            r_cpr       <= n_cpr;
            r_prev      <= n_prev;
            r_int       <= n_int;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg     <= n_deg;
        r_pos     <= n_pos;
        r_ticks   <= n_ticks;
        r_err     <= n_err;
        r_emag    <= n_emag;
        r_eneg    <= n_eneg;
        r_dmag    <= n_dmag;
        r_dneg    <= n_dneg;
        r_eprod   <= n_eprod;
        r_imag    <= n_imag;
        r_ineg    <= n_ineg;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_cnt     <= n_cnt;
        r_pcnt    <= n_pcnt;
        r_pp      <= n_pp;
        r_pp_neg  <= n_pp_neg;
        r_pp_sh   <= n_pp_sh;
        r_acc     <= n_acc;
        r_sneg    <= n_sneg;
        r_duty    <= n_duty;
        r_dir     <= n_dir;
        r_u       <= n_u;
    end

endmodule
`default_nettype wire

// ===== sim/pid_motor_position_drive_chk.sv =====
// Checker for the position PID drive: predicts each control step and compares results.
`timescale 1ns / 1ps
module pid_motor_position_drive_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    pmd_in_if           i_step_ch,
    pmd_out_if          i_drive_ch,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_results
);

    typedef struct packed {
        logic        [7:0]  duty;
        pmd_pkg::t_dir      direction;
        logic signed [31:0] control_value;
    } t_drive_result;

    localparam longint ERR_MAX = 64'sh7FFF_FFFF;
    localparam longint ERR_MIN = -64'sh8000_0000;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -64'sh8000_0000_0000;
    localparam logic signed [127:0] U_MAX   = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] U_MIN   = -128'sh8000_0000;
    localparam logic signed [127:0] Q16_ONE = 128'sd65536;

    logic signed [31:0] kp_gain;
    logic signed [31:0] kd_gain;
    logic signed [31:0] ki_gain;
    logic        [15:0] cpr;
    longint             last_err;
    longint             err_acc;

    t_drive_result pending_drive[$];

    task automatic predict_drive(input logic [8:0] deg, input logic signed [31:0] pos,
                                 input logic [15:0] ticks);
        longint             target_cnt;
        longint             err;
        longint             rate;
        longint             mag;
        logic signed [127:0] w_kp, w_kd, w_ki, w_err, w_rate, w_acc;
        logic signed [127:0] sum;
        logic signed [127:0] quot;
        logic signed [31:0] u;
        t_drive_result      want;
        target_cnt = longint'(deg) * longint'(cpr) / 64'sd360;
        err = longint'(pos) - target_cnt;
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        // no derivative, no integration on a zero-length step
        rate = 0;
        if (ticks != 16'd0) rate = (err - last_err) / longint'(ticks);
        err_acc = err_acc + err * longint'(ticks);
        if (err_acc > ACC_MAX) err_acc = ACC_MAX;
        if (err_acc < ACC_MIN) err_acc = ACC_MIN;
        last_err = err;
        w_kp   = kp_gain;
        w_kd   = kd_gain;
        w_ki   = ki_gain;
        w_err  = err;
        w_rate = rate;
        w_acc  = err_acc;
        sum  = w_kp * w_err + w_kd * w_rate + w_ki * w_acc;
        quot = sum / Q16_ONE;
        if (quot > U_MAX)
            u = U_MAX[31:0];
        else if (quot < U_MIN)
            u = U_MIN[31:0];
        else
            u = quot[31:0];
        want.control_value = u;
        if (u > 0) begin
            want.direction = pmd_pkg::DIR_CW;
            want.duty = (u > 255) ? pmd_pkg::DUTY_MAX : u[7:0];
        end else if (u < 0) begin
            mag = -longint'(u);
            want.direction = pmd_pkg::DIR_CCW;
            want.duty = (mag > 255) ? pmd_pkg::DUTY_MAX : mag[7:0];
        end else begin
            want.direction = pmd_pkg::DIR_STOP;
            want.duty = 8'd0;
        end
        pending_drive.push_back(want);
    endtask

    task automatic check_drive();
        t_drive_result want;
        if (pending_drive.size() == 0) begin
            $error("result with no step outstanding: duty %0d direction %0d control_value %0d",
                   i_drive_ch.duty, i_drive_ch.direction, $signed(i_drive_ch.control_value));
            o_mismatches++;
        end else begin
            want = pending_drive.pop_front();
            o_results++;
            if (i_drive_ch.duty !== want.duty) begin
                $error("duty: expected %0d, got %0d", want.duty, i_drive_ch.duty);
                o_mismatches++;
            end
            if (i_drive_ch.direction !== want.direction) begin
                $error("direction: expected %0d, got %0d", want.direction,
                       i_drive_ch.direction);
                o_mismatches++;
            end
            if (i_drive_ch.control_value !== want.control_value) begin
                $error("control_value: expected %0d, got %0d", $signed(want.control_value),
                       $signed(i_drive_ch.control_value));
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp_gain  = pmd_pkg::GAIN_P_RESET;
            kd_gain  = pmd_pkg::GAIN_D_RESET;
            ki_gain  = pmd_pkg::GAIN_I_RESET;
            cpr      = pmd_pkg::CPR_RESET;
            last_err = 0;
            err_acc  = 0;
            pending_drive.delete();
            o_mismatches = 0;
            o_results    = 0;
        end else begin
            // an outgoing result always belongs to an older step than a same-edge request
            if (i_drive_ch.valid && i_drive_ch.ready) check_drive();
            if (i_step_ch.valid && i_step_ch.ready)
                predict_drive(i_step_ch.target_degrees, i_step_ch.position_count,
                              i_step_ch.elapsed_ticks);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pmd_pkg::CFG_GAIN_P: kp_gain = i_cfg_data;
                    pmd_pkg::CFG_GAIN_D: kd_gain = i_cfg_data;
                    pmd_pkg::CFG_GAIN_I: ki_gain = i_cfg_data;
                    pmd_pkg::CFG_CPR:    cpr     = i_cfg_data[15:0];
                    default:             ;
                endcase
            end
        end
        o_outstanding = pending_drive.size();
    end

endmodule

// ===== sim/pid_motor_position_drive_tb.sv =====
// Testbench top for the position PID drive: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps
module pid_motor_position_drive_tb;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_STEPS  = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          steps_sent;
    int          quiet_cycles;
    int          mismatches;
    int          outstanding;
    int          results;
    logic [15:0] cur_cpr;
    logic [31:0] rnd_kp;
    logic [31:0] rnd_kd;

    pmd_in_if  step_ch ();
    pmd_out_if drive_ch ();

    pid_motor_position_drive u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (step_ch),
        .o_out      (drive_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pid_motor_position_drive_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_step_ch     (step_ch),
        .i_drive_ch    (drive_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        drive_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if ((step_ch.valid && step_ch.ready) || (drive_ch.valid && drive_ch.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("pid_motor_position_drive_tb: errors");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_step(input logic [8:0] deg, input logic signed [31:0] pos,
                             input logic [15:0] ticks);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            step_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        step_ch.valid          <= 1'b1;
        step_ch.target_degrees <= deg;
        step_ch.position_count <= pos;
        step_ch.elapsed_ticks  <= ticks;
        @(posedge i_clk);
        while (!step_ch.ready) @(posedge i_clk);
        steps_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic [8:0]  deg;
        logic [15:0] ticks;
        longint      aim;
        longint      spot;
        logic [31:0] pos;
        for (int k = 0; k < n; k++) begin
            deg = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 360))
                                             : 9'($urandom_range(0, 511));
            aim = longint'(deg) * longint'(cur_cpr) / 360;
            // mostly near the target so the duty stays off its clamp
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: spot = aim + longint'($urandom_range(0, 600)) - 300;
                6, 7:             spot = aim + longint'($urandom_range(0, 200000)) - 100000;
                default:          spot = longint'($urandom());
            endcase
            pos = spot[31:0];
            case ($urandom_range(0, 9))
                0:                ticks = 16'd0;
                1, 2, 3, 4, 5, 6: ticks = 16'($urandom_range(1, 64));
                7, 8:             ticks = 16'($urandom_range(1, 4000));
                default:          ticks = 16'($urandom_range(0, 65535));
            endcase
            send_step(deg, pos, ticks);
        end
    endtask

    task automatic write_reg(input pmd_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] kp, input logic [31:0] kd,
                             input logic [31:0] ki, input logic [15:0] cpr);
        write_reg(pmd_pkg::CFG_GAIN_P, kp);
        write_reg(pmd_pkg::CFG_GAIN_D, kd);
        write_reg(pmd_pkg::CFG_GAIN_I, ki);
        write_reg(pmd_pkg::CFG_CPR, {16'd0, cpr});
        cur_cpr = cpr;
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] kp,
                             input logic [31:0] kd, input logic [31:0] ki,
                             input logic [15:0] cpr);
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        configure(kp, kd, ki, cpr);
        send_random(PHASE_STEPS);
        step_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = pmd_pkg::CFG_GAIN_P;
        i_cfg_data             = 32'd0;
        step_ch.valid          = 1'b0;
        step_ch.target_degrees = 9'd0;
        step_ch.position_count = 32'sd0;
        step_ch.elapsed_ticks  = 16'd0;
        drive_ch.ready         = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        steps_sent             = 0;
        quiet_cycles           = 0;
        cur_cpr                = pmd_pkg::CPR_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset gains: stop, on target, out-of-range target, zero ticks, error clamp
        send_step(9'd0,   32'sd0,          16'd0);
        send_step(9'd360, 32'sd40800,      16'd1);
        send_step(9'd90,  32'sd10000,      16'd10);
        send_step(9'd511, 32'sd0,          16'd5);
        send_step(9'd180, 32'sd20400,      16'd0);
        send_step(9'd360, 32'sh8000_0000,  16'd65535);
        send_step(9'd0,   32'sh7FFF_FFFF,  16'd65535);
        step_ch.valid <= 1'b0;
        wait_drained();

        // unity kp, target in degrees: duty around its clamp in both directions
        configure(32'h0001_0000, 32'd0, 32'd0, 16'd360);
        send_step(9'd100, 32'sd100,  16'd1);
        send_step(9'd100, 32'sd101,  16'd1);
        send_step(9'd100, 32'sd99,   16'd1);
        send_step(9'd100, 32'sd354,  16'd1);
        send_step(9'd100, 32'sd355,  16'd1);
        send_step(9'd100, 32'sd356,  16'd1);
        send_step(9'd100, -32'sd155, 16'd1);
        send_step(9'd100, -32'sd156, 16'd1);
        step_ch.valid <= 1'b0;
        wait_drained();

        // integral clamps high, then low, then is walked back to exactly zero
        configure(32'd0, 32'hFFFF_0000, 32'd1, 16'd360);
        send_step(9'd0, 32'sh7FFF_FFFF, 16'd65535);
        send_step(9'd0, 32'sh7FFF_FFFF, 16'd65535);
        send_step(9'd0, 32'sh8000_0000, 16'd65535);
        send_step(9'd0, 32'sh8000_0000, 16'd65535);
        send_step(9'd0, 32'sh8000_0000, 16'd65535);
        send_step(9'd0, 32'sh8000_0000, 16'd65535);
        send_step(9'd0, 32'sh7FFF_FFFF, 16'd65535);
        send_step(9'd0, 32'sd32768,     16'd65535);
        send_step(9'd0, 32'sd98303,     16'd1);
        step_ch.valid <= 1'b0;

        run_phase(0, 0, 32'h0001_0000, 32'd6554, 32'd0, pmd_pkg::CPR_RESET);
        run_phase(80, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        run_phase(0, 80, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
        rnd_kp = $urandom_range(0, 262143) - 131072;
        rnd_kd = $urandom();
        run_phase(34, 34, rnd_kp, rnd_kd, 32'd1, 16'd0);
        wait_drained();

        $display("%0d control steps sent, %0d results checked, %0d mismatches",
                 steps_sent, results, mismatches);
        $display("gains at reset, unity, extreme and random; counts/rev 0..65535; four pacings");
        if (mismatches == 0) begin
            $display("pid_motor_position_drive_tb: clean");
        end else begin
            $display("pid_motor_position_drive_tb: errors");
        end
        $finish;
    end

endmodule
